// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clk edge, held off while rst is high
`define CHECK_HOLD(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// check on every rising clk edge, reset included
`define CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== rtl/cosdist_pkg.sv =====
// Constants and types shared by the cosine distance block
`timescale 1ns / 1ps

package cosdist_pkg;

  localparam int ELEM_BITS  = 16;
  localparam int MAX_LEN    = 4096;
  localparam int DOT_W      = 2 * ELEM_BITS + $clog2(MAX_LEN);
  localparam int NORM_W     = DOT_W - 1;
  localparam int DIST_W     = 18;
  localparam int IN_DATA_W  = 2 * ELEM_BITS;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  localparam int ONE_Q16    = 1 << (DIST_W - 2);
  localparam int TWO_Q16    = 1 << (DIST_W - 1);
  localparam int L_SHIFT    = 2 * (DIST_W - 1);

  localparam int LIMB_W     = 32;
  localparam int X_LIMBS    = 3;
  localparam int Y_LIMBS    = 2;
  localparam int X_W        = X_LIMBS * LIMB_W;
  localparam int Y_W        = Y_LIMBS * LIMB_W;
  localparam int PROD_W     = 128;
  localparam int PP_W       = 2 * NORM_W;
  localparam int K2_W       = 2 * DIST_W;

  typedef struct packed {
    logic           start;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [NORM_W-1:0] src_norm;
    logic [NORM_W-1:0] tst_norm;
    logic              pend;
  } acc_sums_t;

endpackage

// ===== rtl/cosdist_accum.sv =====
// Running dot product and squared norms with saturation
`timescale 1ns / 1ps

module cosdist_accum import cosdist_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [ELEM_BITS-1:0] src,
  input  logic signed [ELEM_BITS-1:0] tst,
  input  logic                        clear,
  output acc_sums_t                   sums
);

  logic signed [2*ELEM_BITS-1:0] p_st;
  logic signed [2*ELEM_BITS-1:0] sq_s;
  logic signed [2*ELEM_BITS-1:0] sq_t;
  logic [2*ELEM_BITS-2:0]        p_ss;
  logic [2*ELEM_BITS-2:0]        p_tt;
  logic                          pv;
  logic [DOT_W-1:0]              dot;
  logic [NORM_W-1:0]             src_norm;
  logic [NORM_W-1:0]             tst_norm;
  logic [DOT_W:0]                dot_ext;
  logic [NORM_W:0]               src_ext;
  logic [NORM_W:0]               tst_ext;
  logic [DOT_W-1:0]              dot_next;
  logic [NORM_W-1:0]             src_next;
  logic [NORM_W-1:0]             tst_next;

  assign sq_s = src * src;
  assign sq_t = tst * tst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= in_valid;
    end
    p_st <= src * tst;
    p_ss <= sq_s[2*ELEM_BITS-2:0];
    p_tt <= sq_t[2*ELEM_BITS-2:0];
  end

  always_comb begin
    dot_ext = {dot[DOT_W-1], dot} + {{(DOT_W+1-2*ELEM_BITS){p_st[2*ELEM_BITS-1]}}, p_st};
    src_ext = {1'b0, src_norm} + (NORM_W+1)'(p_ss);
    tst_ext = {1'b0, tst_norm} + (NORM_W+1)'(p_tt);
    if (dot_ext[DOT_W] != dot_ext[DOT_W-1]) begin
      dot_next = dot_ext[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_next = dot_ext[DOT_W-1:0];
    end
    src_next = src_ext[NORM_W] ? {NORM_W{1'b1}} : src_ext[NORM_W-1:0];
    tst_next = tst_ext[NORM_W] ? {NORM_W{1'b1}} : tst_ext[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      dot      <= '0;
      src_norm <= '0;
      tst_norm <= '0;
    end else if (pv) begin
      dot      <= dot_next;
      src_norm <= src_next;
      tst_norm <= tst_next;
    end
  end

  assign sums.dot      = dot;
  assign sums.src_norm = src_norm;
  assign sums.tst_norm = tst_norm;
  assign sums.pend     = pv;

endmodule

// ===== rtl/cosdist_mul.sv =====
// Shared multi-limb multiplier: one 32x32 product per cycle into a wide accumulator
`timescale 1ns / 1ps

module cosdist_mul import cosdist_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int XI_W = (X_LIMBS > 1) ? $clog2(X_LIMBS) : 1;
  localparam int YJ_W = (Y_LIMBS > 1) ? $clog2(Y_LIMBS) : 1;
  localparam int SH_W = $clog2(X_LIMBS + Y_LIMBS);

  logic [X_W-1:0]      xr;
  logic [Y_W-1:0]      yr;
  logic [XI_W-1:0]     xi;
  logic [YJ_W-1:0]     yj;
  logic                issue;
  logic                issue_last;
  logic                yj_last;
  logic [LIMB_W-1:0]   xl;
  logic [LIMB_W-1:0]   yl;
  logic [2*LIMB_W-1:0] pp_next;
  logic [2*LIMB_W-1:0] pp;
  logic [SH_W-1:0]     psh;
  logic                pv;
  logic                plast;
  logic [PROD_W-1:0]   acc;

  assign xl         = xr[xi*LIMB_W +: LIMB_W];
  assign yl         = yr[yj*LIMB_W +: LIMB_W];
  assign pp_next    = xl * yl;
  assign yj_last    = (yj == YJ_W'(Y_LIMBS - 1));
  assign issue_last = (xi == XI_W'(X_LIMBS - 1)) && yj_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= pv && plast;
      pv   <= issue;
      if (req.start) begin
        issue <= 1'b1;
      end else if (issue && issue_last) begin
        issue <= 1'b0;
      end
    end
    if (pv) begin
      acc <= acc + (PROD_W'(pp) << (psh * LIMB_W));
    end
    if (req.start) begin
      xr  <= req.x;
      yr  <= req.y;
      xi  <= '0;
      yj  <= '0;
      acc <= '0;
    end else if (issue) begin
      pp    <= pp_next;
      psh   <= SH_W'(xi) + SH_W'(yj);
      plast <= issue_last;
      if (yj_last) begin
        yj <= '0;
        xi <= xi + XI_W'(1);
      end else begin
        yj <= yj + YJ_W'(1);
      end
    end
  end

  assign prod = acc;

endmodule

// ===== rtl/cosine_distance_top.sv =====
// Cosine distance between two streamed vectors: top level with search sequencer
//
// Input channel s_axis: one word per element pair, source element in tdata[15:0],
// test element in tdata[31:16], both signed Q1.14; tlast marks the final pair.
// Pairs are taken one per cycle while the block accumulates.
// Output channel m_axis: one word per vector pair, distance 1 - a/sqrt(b*c) as
// unsigned Q2.16 in tdata[17:0], zero_norm in tuser (distance then 0).
// After the last pair, tready drops while a single 32x32 multiplier is stepped
// through a binary search on the distance: first b*c and a*a, then up to 19 search
// steps, each of which forms k*k, then k*k*b*c, unless the signs decide it.
// A zero norm skips the multiplier and the binary search entirely.
// The result sits in an output register, so the next vector pair streams in
// while it waits; a second result waits in the sequencer until the first is taken.
// Synchronous reset clears all sums, empties the output and makes tready high.
`timescale 1ns / 1ps

module cosine_distance_top import cosdist_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // source_element, test_element
  input  logic                  s_axis_tlast,   // last_pair
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // distance, zero fill
  output logic                  m_axis_tuser    // zero_norm
);

  typedef enum logic [3:0] {
    ST_ACCUM, ST_WAIT, ST_BC, ST_A2, ST_TEST, ST_K2, ST_KP, ST_APPLY, ST_SEARCH, ST_FINISH
  } state_t;

  localparam logic [DIST_W:0] K_BASE = (DIST_W+1)'(TWO_Q16 + 1);

  state_t              state;
  acc_sums_t           sums;
  logic                acc_clear;
  mul_req_t            req;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                accept;
  logic                a_le_zero;
  logic [DOT_W-1:0]    a_mag;
  logic                k_pos;
  logic [DIST_W:0]     twice_mid;
  logic [DIST_W-1:0]   k_mag;
  logic [DIST_W:0]     span;
  logic [DIST_W-1:0]   mid_next;
  logic [PP_W-1:0]     pp;
  logic [PROD_W-1:0]   l2;
  logic [DIST_W-1:0]   lo;
  logic [DIST_W-1:0]   hi;
  logic [DIST_W-1:0]   mid;
  logic                first;
  logic                pass;
  logic [DIST_W-1:0]   result;
  logic                result_zn;

  cosdist_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .src      (s_axis_tdata[ELEM_BITS-1:0]),
    .tst      (s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .clear    (acc_clear),
    .sums     (sums)
  );

  cosdist_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign s_axis_tready = (state == ST_ACCUM);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign a_le_zero = sums.dot[DOT_W-1] || (sums.dot == '0);
  assign a_mag     = sums.dot[DOT_W-1] ? (~sums.dot + DOT_W'(1)) : sums.dot;
  assign k_pos     = (mid <= DIST_W'(ONE_Q16));
  assign twice_mid = {mid, 1'b0};
  assign k_mag     = k_pos ? DIST_W'(K_BASE - twice_mid) : DIST_W'(twice_mid - K_BASE);
  assign span      = {1'b0, hi} - {1'b0, lo} + (DIST_W+1)'(1);
  assign mid_next  = lo + DIST_W'(span >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_ACCUM;
      req.start     <= 1'b0;
      acc_clear     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      first         <= 1'b0;
    end else begin
      if (req.start) begin
        req.start <= 1'b0;
      end
      if (acc_clear) begin
        acc_clear <= 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_ACCUM: begin
          if (accept && s_axis_tlast) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!sums.pend) begin
            if (sums.src_norm == '0 || sums.tst_norm == '0) begin
              result    <= '0;
              result_zn <= 1'b1;
              state     <= ST_FINISH;
            end else begin
              req.start <= 1'b1;
              req.x     <= X_W'(sums.src_norm);
              req.y     <= Y_W'(sums.tst_norm);
              state     <= ST_BC;
            end
          end
        end
        ST_BC: begin
          if (mul_done) begin
            pp        <= mul_prod[PP_W-1:0];
            req.start <= 1'b1;
            req.x     <= X_W'(a_mag);
            req.y     <= Y_W'(a_mag);
            state     <= ST_A2;
          end
        end
        ST_A2: begin
          if (mul_done) begin
            l2    <= mul_prod << L_SHIFT;
            mid   <= '0;
            lo    <= '0;
            hi    <= DIST_W'(TWO_Q16);
            first <= 1'b1;
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (a_le_zero && k_pos) begin
            pass  <= 1'b1;
            state <= ST_APPLY;
          end else if (!a_le_zero && !k_pos) begin
            pass  <= 1'b0;
            state <= ST_APPLY;
          end else begin
            req.start <= 1'b1;
            req.x     <= X_W'(k_mag);
            req.y     <= Y_W'(k_mag);
            state     <= ST_K2;
          end
        end
        ST_K2: begin
          if (mul_done) begin
            req.start <= 1'b1;
            req.x     <= X_W'(pp);
            req.y     <= Y_W'(mul_prod[K2_W-1:0]);
            state     <= ST_KP;
          end
        end
        ST_KP: begin
          if (mul_done) begin
            pass  <= k_pos ? (l2 <= mul_prod) : (l2 >= mul_prod);
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (first) begin
            first <= 1'b0;
            if (!pass) begin
              result    <= '0;
              result_zn <= 1'b0;
              state     <= ST_FINISH;
            end else begin
              state <= ST_SEARCH;
            end
          end else begin
            if (pass) begin
              lo <= mid;
            end else begin
              hi <= mid - DIST_W'(1);
            end
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= ST_TEST;
          end else begin
            result    <= lo;
            result_zn <= 1'b0;
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_DATA_W'(result);
            m_axis_tuser  <= result_zn;
            acc_clear     <= 1'b1;
            state         <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cosdist_checker.sv =====
// Port-level checks for the cosine distance block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosdist_checker import cosdist_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  `CHECK_HOLD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `CHECK_HOLD(a_zero_norm, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
  `CHECK_HOLD(a_range, m_axis_tvalid |-> m_axis_tdata <= OUT_DATA_W'(TWO_Q16))
  `CHECK_HOLD(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
  `CHECK_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid)

endmodule

bind cosine_distance_top cosdist_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/cosine_distance_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for cosine_distance_top: streams vector pairs, predicts and checks each distance
module cosine_distance_top_tb;
  import cosdist_pkg::*;

  localparam int     HOLD_LEN    = 3000;
  localparam int     DRAIN_WAIT  = 500;
  localparam int     CYCLE_LIMIT = 1500000;
  localparam int     ELEM_MAX    = (1 << (ELEM_BITS - 1)) - 1;
  localparam int     ELEM_MIN    = -(1 << (ELEM_BITS - 1));
  localparam longint DOT_HI      = (longint'(1) << (DOT_W - 1)) - 1;
  localparam longint DOT_LO      = -(longint'(1) << (DOT_W - 1));
  localparam longint NORM_HI     = (longint'(1) << NORM_W) - 1;

  typedef logic signed [ELEM_BITS-1:0] elem_t;

  typedef struct {
    elem_t src;
    elem_t tst;
    logic  is_last;
    int    send_idle;
    int    recv_stall;
    bit    hold;
  } pair_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              zero_norm;
  } dist_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // source_element, test_element
  logic                  s_axis_tlast = 1'b0;  // last_pair
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // distance, zero fill
  logic                  m_axis_tuser;         // zero_norm

  pair_t pending_pairs[$];
  dist_t expected_dists[$];
  pair_t next_pair;
  dist_t want;

  logic signed [DOT_W-1:0] dot_acc = '0;
  logic [NORM_W-1:0]       src_sq_acc = '0;
  logic [NORM_W-1:0]       tst_sq_acc = '0;

  int cur_send_idle = 0;
  int cur_recv_stall = 0;
  bit cur_hold = 1'b0;
  int items_added = 0;

  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  int fail_count = 0;
  int cycle_count = 0;
  wire holding = hold_go && (hold_cnt < HOLD_LEN);

  cosine_distance_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // true when the rounded distance is at least n: 2^17*a <= (2^17 + 1 - 2n)*sqrt(b*c)
  function automatic bit dist_not_below(longint a, longint b, longint c, longint n);
    longint     k;
    longint     l;
    logic [127:0] ul;
    logic [127:0] uk;
    logic [127:0] lhs;
    logic [127:0] rhs;
    k = TWO_Q16 + 1 - 2 * n;
    l = a * TWO_Q16;
    if (l <= 0 && k > 0) return 1'b1;
    if (l > 0 && k < 0) return 1'b0;
    ul = 128'((l < 0) ? -l : l);
    uk = 128'((k < 0) ? -k : k);
    lhs = ul * ul;
    rhs = uk * uk * 128'(b) * 128'(c);
    return (k > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  function automatic longint cosine_dist_q16(longint a, longint b, longint c);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = TWO_Q16;
    if (!dist_not_below(a, b, c, 0)) return 0;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (dist_not_below(a, b, c, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void accumulate_pair(elem_t s, elem_t t, logic is_last);
    longint d;
    longint ns;
    longint nt;
    longint q;
    dist_t  r;
    d  = longint'(dot_acc) + longint'(s) * longint'(t);
    ns = longint'(src_sq_acc) + longint'(s) * longint'(s);
    nt = longint'(tst_sq_acc) + longint'(t) * longint'(t);
    dot_acc    = DOT_W'((d > DOT_HI) ? DOT_HI : ((d < DOT_LO) ? DOT_LO : d));
    src_sq_acc = NORM_W'((ns > NORM_HI) ? NORM_HI : ns);
    tst_sq_acc = NORM_W'((nt > NORM_HI) ? NORM_HI : nt);
    if (!is_last) return;
    if (src_sq_acc == 0 || tst_sq_acc == 0) begin
      r.distance  = '0;
      r.zero_norm = 1'b1;
    end else begin
      q = cosine_dist_q16(longint'(dot_acc), longint'(src_sq_acc), longint'(tst_sq_acc));
      r.distance  = q[DIST_W-1:0];
      r.zero_norm = 1'b0;
    end
    expected_dists.insert(expected_dists.size(), r);
    dot_acc    = '0;
    src_sq_acc = '0;
    tst_sq_acc = '0;
  endfunction

  function automatic int sat_elem(int v);
    return (v > ELEM_MAX) ? ELEM_MAX : ((v < ELEM_MIN) ? ELEM_MIN : v);
  endfunction

  function automatic int rand_elem();
    return int'($urandom_range(65535)) + ELEM_MIN;
  endfunction

  function automatic int edge_elem();
    case ($urandom_range(4))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic void add_pair(int s, int t, bit is_last);
    pair_t p;
    p.src        = s[ELEM_BITS-1:0];
    p.tst        = t[ELEM_BITS-1:0];
    p.is_last    = is_last;
    p.send_idle  = cur_send_idle;
    p.recv_stall = cur_recv_stall;
    p.hold       = cur_hold;
    cur_hold     = 1'b0;
    pending_pairs.insert(pending_pairs.size(), p);
    items_added++;
  endfunction

  function automatic void add_vector(int len);
    int mode;
    int s;
    int t;
    mode = $urandom_range(11);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          s = 0;
          t = rand_elem();
        end
        1: begin
          s = rand_elem();
          t = 0;
        end
        2, 3: begin
          s = rand_elem();
          t = sat_elem(s + int'($urandom_range(64)) - 32);
        end
        4: begin
          s = rand_elem();
          t = sat_elem(-s + int'($urandom_range(64)) - 32);
        end
        5: begin
          s = edge_elem();
          t = edge_elem();
        end
        6: begin
          s = int'($urandom_range(16)) - 8;
          t = int'($urandom_range(16)) - 8;
        end
        default: begin
          s = rand_elem();
          t = rand_elem();
        end
      endcase
      add_pair(s, t, i == len - 1);
    end
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(32, 9);
    return $urandom_range(100, 33);
  endfunction

  function automatic void fill_phase(int n_items, int send_idle, int recv_stall);
    int target;
    target = items_added + n_items;
    cur_send_idle  = send_idle;
    cur_recv_stall = recv_stall;
    while (items_added < target) add_vector(pick_len());
  endfunction

  // accept a pair, then offer the next one unless the sender idles
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        accumulate_pair($signed(s_axis_tdata[ELEM_BITS-1:0]),
                        $signed(s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]), s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() != 0 &&
            $urandom_range(99) >= pending_pairs[0].send_idle) begin
          next_pair = pending_pairs.pop_front();
          s_axis_tvalid  <= 1'b1;
          s_axis_tdata   <= {next_pair.tst, next_pair.src};
          s_axis_tlast   <= next_pair.is_last;
          recv_stall_pct <= next_pair.recv_stall;
          if (next_pair.hold) hold_go <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (holding) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dists.size() == 0) begin
          $error("unexpected word: distance %0d zero_norm %0d",
                 m_axis_tdata[DIST_W-1:0], m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_dists.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== want.distance ||
              m_axis_tuser !== want.zero_norm)
            fail_count <= fail_count + 1;
          if (m_axis_tdata[DIST_W-1:0] !== want.distance)
            $error("distance: expected %0d, got %0d", want.distance,
                   m_axis_tdata[DIST_W-1:0]);
          if (m_axis_tuser !== want.zero_norm)
            $error("zero_norm: expected %0d, got %0d", want.zero_norm, m_axis_tuser);
        end
      end
      m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cosine_distance_top: mismatch");
      $finish;
    end
  end

  initial begin
    cur_send_idle  = 0;
    cur_recv_stall = 0;

    add_pair(ELEM_MAX, ELEM_MAX, 1);
    add_pair(ELEM_MAX, ELEM_MIN, 1);
    add_pair(ELEM_MIN, ELEM_MIN, 1);
    add_pair(0, 0, 1);
    add_pair(0, 12345, 1);
    add_pair(-7, 0, 1);
    add_pair(0, 5, 0);
    add_pair(0, -5, 1);
    add_pair(16384, 0, 0);
    add_pair(0, 16384, 1);
    add_pair(1, 1, 0);
    add_pair(1, -1, 1);
    add_pair(1, -1, 1);
    add_pair(-1, -1, 1);
    add_pair(21845, -21846, 0);
    add_pair(-21846, 21845, 1);
    add_pair(ELEM_MAX, ELEM_MAX - 1, 0);
    add_pair(ELEM_MIN, ELEM_MIN + 1, 0);
    add_pair(3, 4, 1);
    add_pair(100, 200, 0);
    add_pair(300, -150, 1);

    // hold the receiver off while short vectors keep coming
    cur_hold = 1'b1;
    for (int i = 0; i < 40; i++) add_vector($urandom_range(3, 1));

    fill_phase(460, 0, 0);
    fill_phase(460, 74, 0);
    fill_phase(460, 0, 74);
    fill_phase(460, 37, 37);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_dists.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("cosine_distance_top: match");
    else
      $display("cosine_distance_top: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cosdist_pkg.sv
rtl/cosdist_accum.sv
rtl/cosdist_mul.sv
rtl/cosine_distance_top.sv
rtl/cosdist_checker.sv
test/cosine_distance_top_tb.sv
